FILE: design/sinc3_decimator_voltage_macros.svh
// Assertion macros shared by the checker of the sinc3 voltage decimator.
`ifndef SINC3_DECIMATOR_VOLTAGE_MACROS_SVH
`define SINC3_DECIMATOR_VOLTAGE_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define SDV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SDV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/sdv_pkg.sv
`timescale 1ns / 1ps

package sdv_pkg;

   // Field and datapath widths.
   localparam int CNT_W      = 16;
   localparam int DATA_W     = 32;
   localparam int FS_W       = 10;
   localparam int CAL_W      = 11;
   localparam int VOLT_W     = 16;
   localparam int DIVR_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ORDER      = 3;

   // Division by a constant through its reciprocal. The quotient is the top
   // word of dividend * ceil(2^RECIP_W / divisor), which is exact for every
   // 32-bit dividend as long as the divisor fits in DIVR_W bits.
   localparam int RECIP_W    = 48;
   localparam int RECIP_HALF = RECIP_W / 2;
   localparam int PROD_W     = DATA_W + RECIP_W;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LIMIT  = 2'd0,
      CSR_HIGH_LIMIT = 2'd1,
      CSR_FULL_SCALE = 2'd2,
      CSR_CALIB      = 2'd3
   } csr_index_type;

   // Register values after reset.
   localparam logic [CNT_W-1:0] LOW_LIMIT_RST  = 16'd40;
   localparam logic [CNT_W-1:0] HIGH_LIMIT_RST = 16'd500;
   localparam logic [FS_W-1:0]  FULL_SCALE_RST = 10'd60;
   localparam logic [CAL_W-1:0] CALIB_RST      = 11'd992;

   // Fixed divisors and factors of the voltage conversion.
   localparam logic [DIVR_W-1:0] CENTER_DIV = 16'd200;
   localparam logic [DIVR_W-1:0] PERMIL_DIV = 16'd1000;
   localparam logic [3:0]        SCALE_TEN  = 4'd10;
   localparam int                CENTER_MUL = 250;

   typedef struct packed {
      logic [FS_W-1:0]  full_scale;
      logic [CAL_W-1:0] calib;
   } conv_cfg_type;

   typedef struct packed {
      logic               start;
      logic [DATA_W-1:0]  dividend;
      logic [RECIP_W-1:0] recip;
   } div_req_type;

endpackage

FILE: design/sdv_integ_cell.sv
`timescale 1ns / 1ps

// One integrator of the chain: adds the value its neighbor held before
// this item and hands its own old value on to the next cell.
module sdv_integ_cell
   import sdv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [DATA_W-1:0] din,
   output logic [DATA_W-1:0] acc
);

   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;

   assign acc_in = acc_ff + din;
   assign acc    = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: design/sdv_comb_cell.sv
`timescale 1ns / 1ps

// One comb of the chain: registers the difference to the value it saw at
// the previous decimation point and hands that difference on.
module sdv_comb_cell
   import sdv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [DATA_W-1:0] din,
   output logic [DATA_W-1:0] dout
);

   logic [DATA_W-1:0] delay_ff;
   logic [DATA_W-1:0] diff_ff;

   assign dout = diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else if (en) begin
         delay_ff <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= din - delay_ff;
      end
   end

endmodule

FILE: design/sdv_div.sv
`timescale 1ns / 1ps

// Divides by a constant through its reciprocal. The 48-bit reciprocal is
// applied as two 24-bit halves, the low half first, and done is raised
// together with the sum that adds in the second half.
module sdv_div
   import sdv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       req,
   output logic              done,
   output logic [DATA_W-1:0] quo
);

   localparam int PART_W = DATA_W + RECIP_HALF;

   typedef enum logic [1:0] {
      D_IDLE, D_LOW, D_HIGH
   } div_state_type;

   div_state_type      state_ff;
   logic               done_ff;
   logic [DATA_W-1:0]  num_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [PROD_W-1:0]  acc_ff;

   logic [RECIP_HALF-1:0] recip_part;
   logic [PART_W-1:0]     part;

   assign recip_part = (state_ff == D_HIGH) ? recip_ff[RECIP_W-1:RECIP_HALF]
                                            : recip_ff[RECIP_HALF-1:0];
   assign part       = PART_W'(num_ff) * PART_W'(recip_part);

   assign done = done_ff;
   assign quo  = acc_ff[PROD_W-1 -: DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         acc_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            num_ff   <= req.dividend;
            recip_ff <= req.recip;
            state_ff <= D_LOW;
         end else begin
            unique case (state_ff)
               D_LOW: begin
                  acc_ff   <= PROD_W'(part);
                  state_ff <= D_HIGH;
               end
               D_HIGH: begin
                  acc_ff   <= acc_ff + {part, {RECIP_HALF{1'b0}}};
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
               default: state_ff <= D_IDLE;
            endcase
         end
      end
   end

endmodule

FILE: design/sdv_conv.sv
`timescale 1ns / 1ps

// Converts the comb output to 100 mV units: three divisions by constants
// on the shared reciprocal divider, with registered multiplies between them.
module sdv_conv
   import sdv_pkg::*;
#(
   parameter int DECIMATION = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] filt,
   input  conv_cfg_type      cfg,
   output logic              done,
   output logic [VOLT_W-1:0] volt
);

   localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_W;
   localparam longint unsigned GAIN      = 64'(DECIMATION * DECIMATION * DECIMATION);
   localparam longint unsigned CENTER_D  = 64'(CENTER_DIV);
   localparam longint unsigned PERMIL_D  = 64'(PERMIL_DIV);
   localparam logic [RECIP_W-1:0] RECIP_CENTER =
      RECIP_W'((RECIP_ONE + CENTER_D - 64'd1) / CENTER_D);
   localparam logic [RECIP_W-1:0] RECIP_GAIN =
      RECIP_W'((RECIP_ONE + GAIN - 64'd1) / GAIN);
   localparam logic [RECIP_W-1:0] RECIP_PERMIL =
      RECIP_W'((RECIP_ONE + PERMIL_D - 64'd1) / PERMIL_D);
   localparam logic [DATA_W-1:0] GAIN_CENTER =
      DATA_W'(DECIMATION * DECIMATION * DECIMATION * CENTER_MUL);

   typedef enum logic [3:0] {
      C_IDLE, C_LD1, C_DIV1, C_MULA, C_LD2, C_DIV2, C_MULB, C_LD3, C_DIV3
   } conv_state_type;

   conv_state_type    state_ff;
   logic [DATA_W-1:0] opnd_ff;
   logic              done_ff;
   logic [VOLT_W-1:0] volt_ff;

   div_req_type       div_req;
   logic              div_done;
   logic [DATA_W-1:0] div_quo;
   logic [DATA_W+3:0] ten_prod;
   logic [DATA_W+FS_W-1:0] fs_prod;
   logic [DATA_W+CAL_W-1:0] cal_prod;

   assign ten_prod = div_quo * SCALE_TEN;
   assign fs_prod  = opnd_ff * cfg.full_scale;
   assign cal_prod = opnd_ff * cfg.calib;

   always_comb begin
      div_req.dividend = opnd_ff;
      div_req.start    = 1'b0;
      div_req.recip    = RECIP_CENTER;
      unique case (state_ff)
         C_LD1: begin
            div_req.start = 1'b1;
            div_req.recip = RECIP_CENTER;
         end
         C_LD2: begin
            div_req.start = 1'b1;
            div_req.recip = RECIP_GAIN;
         end
         C_LD3: begin
            div_req.start = 1'b1;
            div_req.recip = RECIP_PERMIL;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   sdv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign done = done_ff;
   assign volt = volt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  opnd_ff  <= GAIN_CENTER - filt;
                  state_ff <= C_LD1;
               end
            end
            C_LD1: state_ff <= C_DIV1;
            C_DIV1: begin
               if (div_done) begin
                  opnd_ff  <= ten_prod[DATA_W-1:0];
                  state_ff <= C_MULA;
               end
            end
            C_MULA: begin
               opnd_ff  <= fs_prod[DATA_W-1:0];
               state_ff <= C_LD2;
            end
            C_LD2: state_ff <= C_DIV2;
            C_DIV2: begin
               if (div_done) begin
                  opnd_ff  <= div_quo;
                  state_ff <= C_MULB;
               end
            end
            C_MULB: begin
               opnd_ff  <= cal_prod[DATA_W-1:0];
               state_ff <= C_LD3;
            end
            C_LD3: state_ff <= C_DIV3;
            C_DIV3: begin
               if (div_done) begin
                  volt_ff  <= div_quo[VOLT_W-1:0];
                  done_ff  <= 1'b1;
                  state_ff <= C_IDLE;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule

FILE: design/sinc3_decimator_voltage.sv
// A plain item goes from acceptance through the emit state into the output register. A
// decimation point first passes the three comb states, a conversion start state and the
// conversion, three constant divisions with two multiply steps between them, then emit.
// One item at a time: the next item is taken only once the last result has been loaded
// into the output register, and that waits while a held result keeps the output full.
// Reset is synchronous and active high; it clears the integrators, the comb delays,
// the decimation phase, the output register and loads the register defaults.
`timescale 1ns / 1ps

// Third-order CIC decimator for sigma-delta edge counts with conversion of
// every decimated value to a calibrated voltage in 100 mV units.
//
// The filter is a chain of cells. Three integrator cells update on every
// accepted item; the first adds the edge count, each later one the value its
// left neighbor held before the item, so the whole row updates together. Three
// comb cells run only on a decimation point, one per cycle, each handing its
// registered difference to the next; the last comb output feeds the converter.
//
// Every accepted item gives exactly one result item. The range flag is worked
// out when the item is accepted; the voltage flag and value are set on
// decimation points only and are zero otherwise. The result sits in an output
// register, so the block takes a new item while the previous result waits.
module sinc3_decimator_voltage
   import sdv_pkg::*;
#(
   parameter int DECIMATION = 16
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CNT_W-1:0]      req_tdata,   // [15:0] edge_count

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VOLT_W-1:0]     rsp_tdata,   // [15:0] voltage_100mv
   output logic [1:0]            rsp_tuser,   // [0] range_error, [1] voltage_valid

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PH_W = $clog2(DECIMATION);
   localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIMATION - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_COMB0, S_COMB1, S_COMB2, S_CONV_START, S_CONV, S_EMIT
   } state_type;

   // Configuration registers. Writes are to come only while the block is idle;
   // the user keeps to this, the block does not enforce it. The port is always ready.
   logic [CNT_W-1:0] low_limit_ff;
   logic [CNT_W-1:0] high_limit_ff;
   logic [FS_W-1:0]  full_scale_ff;
   logic [CAL_W-1:0] calib_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= LOW_LIMIT_RST;
         high_limit_ff <= HIGH_LIMIT_RST;
         full_scale_ff <= FULL_SCALE_RST;
         calib_ff      <= CALIB_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOW_LIMIT:  low_limit_ff  <= csr_data;
            CSR_HIGH_LIMIT: high_limit_ff <= csr_data;
            CSR_FULL_SCALE: full_scale_ff <= csr_data[FS_W-1:0];
            CSR_CALIB:      calib_ff      <= csr_data[CAL_W-1:0];
            default: ;
         endcase
      end
   end

   state_type         state_ff;
   logic [PH_W-1:0]   phase_ff;
   logic              err_ff;
   logic              dec_ff;
   logic              rsp_tvalid_ff;
   logic [VOLT_W-1:0] rsp_tdata_ff;
   logic [1:0]        rsp_tuser_ff;

   logic              accept;
   logic              range_err;
   logic              slot_free;
   logic              rsp_load;
   logic [ORDER-1:0]  comb_en;
   logic              conv_start;
   logic              conv_done;
   logic [VOLT_W-1:0] conv_volt;
   conv_cfg_type      conv_cfg;

   logic [DATA_W-1:0] integ_in  [ORDER];
   logic [DATA_W-1:0] integ_acc [ORDER];
   logic [DATA_W-1:0] comb_in   [ORDER];
   logic [DATA_W-1:0] comb_out  [ORDER];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign range_err  = (req_tdata < low_limit_ff) || (req_tdata > high_limit_ff);
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load   = (state_ff == S_EMIT) && slot_free;
   assign conv_start = (state_ff == S_CONV_START);

   assign conv_cfg.full_scale = full_scale_ff;
   assign conv_cfg.calib      = calib_ff;

   // One comb cell works per cycle as the decimated value walks down the row.
   always_comb begin
      comb_en = '0;
      unique case (state_ff)
         S_COMB0: comb_en[0] = 1'b1;
         S_COMB1: comb_en[1] = 1'b1;
         S_COMB2: comb_en[2] = 1'b1;
         default: comb_en = '0;
      endcase
   end

   // The first integrator takes the edge count; each later one takes the old
   // value of its left neighbor. The first comb sees the updated last
   // integrator, which is in place in the cycle after the item was accepted.
   assign integ_in[0] = {{(DATA_W-CNT_W){1'b0}}, req_tdata};
   assign comb_in[0]  = integ_acc[ORDER-1];

   genvar k;
   generate
      for (k = 1; k < ORDER; k++) begin : g_link
         assign integ_in[k] = integ_acc[k-1];
         assign comb_in[k]  = comb_out[k-1];
      end
      for (k = 0; k < ORDER; k++) begin : g_cell
         sdv_integ_cell u_integ (
            .clock (clock),
            .reset (reset),
            .en    (accept),
            .din   (integ_in[k]),
            .acc   (integ_acc[k])
         );
         sdv_comb_cell u_comb (
            .clock (clock),
            .reset (reset),
            .en    (comb_en[k]),
            .din   (comb_in[k]),
            .dout  (comb_out[k])
         );
      end
   endgenerate

   sdv_conv #(
      .DECIMATION (DECIMATION)
   ) u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .filt  (comb_out[ORDER-1]),
      .cfg   (conv_cfg),
      .done  (conv_done),
      .volt  (conv_volt)
   );

   // Sequencer and output register. A result is loaded when the output
   // register is empty or is being emptied in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= '0;
         err_ff        <= 1'b0;
         dec_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tuser_ff  <= {dec_ff, err_ff};
            rsp_tdata_ff  <= dec_ff ? conv_volt : '0;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  err_ff <= range_err;
                  if (phase_ff == PH_LAST) begin
                     phase_ff <= '0;
                     dec_ff   <= 1'b1;
                     state_ff <= S_COMB0;
                  end else begin
                     phase_ff <= phase_ff + PH_W'(1);
                     dec_ff   <= 1'b0;
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_COMB0:      state_ff <= S_COMB1;
            S_COMB1:      state_ff <= S_COMB2;
            S_COMB2:      state_ff <= S_CONV_START;
            S_CONV_START: state_ff <= S_CONV;
            S_CONV: begin
               if (conv_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: design/sdv_checker.sv
`timescale 1ns / 1ps
`include "sinc3_decimator_voltage_macros.svh"

// Port-level checks on the sinc3 voltage decimator.
module sdv_checker
   import sdv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [VOLT_W-1:0] rsp_tdata,
   input logic [1:0]        rsp_tuser
);

   // A waiting result keeps its payload.
   `SDV_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed while stalled")

   // Off a decimation point the voltage field reads zero.
   `SDV_ASSERT(a_volt_zero, rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata == '0, "voltage set without voltage_valid")

   // One item at a time: the input closes right after an item is taken.
   `SDV_ASSERT(a_one_item, req_tvalid && req_tready |=> !req_tready, "second item taken back to back")

   // Reset empties the output register.
   `SDV_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind sinc3_decimator_voltage sdv_checker u_sdv_checker (.*);

FILE: test/sinc3_decimator_voltage_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the sinc3 voltage decimator. A driver process
// pulls edge counts from a queue and offers them on the request stream. A
// monitor process takes results from the response stream. Every accepted
// edge count runs through a local copy of the filter and the converter,
// which queues the reading that the block should return for it.
module sinc3_decimator_voltage_test;
   import sdv_pkg::*;

   localparam int DECIM        = 16;
   localparam logic [31:0] FILTER_GAIN = DECIM * DECIM * DECIM;
   // The cycle limit only catches a hung handshake.
   localparam int CYCLE_LIMIT  = 400000;
   // Length of the single long receiver hold-off that fills the block.
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 235;

   // Idle patterns that the driver and the monitor apply during one phase.
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One result item as the block should report it.
   typedef struct packed {
      logic              range_error;
      logic              voltage_valid;
      logic [VOLT_W-1:0] voltage_100mv;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CNT_W-1:0]      req_tdata  = '0;   // [15:0] edge_count

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VOLT_W-1:0]     rsp_tdata;         // [15:0] voltage_100mv
   logic [1:0]            rsp_tuser;         // [0] range_error, [1] voltage_valid

   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   sinc3_decimator_voltage #(.DECIMATION(DECIM)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Local copy of the block's settings, updated when a register write is
   // accepted. They start at the reset defaults.
   logic [31:0] low_limit  = 32'd40;
   logic [31:0] high_limit = 32'd500;
   logic [31:0] full_scale = 32'd60;
   logic [31:0] calib      = 32'd992;

   // Local copy of the filter state.
   logic [31:0] integ_acc [3] = '{default: '0};
   logic [31:0] comb_hist [3] = '{default: '0};
   logic [4:0]  decim_count   = '0;

   logic [CNT_W-1:0] pending_counts [$];
   reading_type      expected_readings [$];

   idle_mode_type idle_mode      = IDLE_NONE;
   logic          pressure_armed = 1'b0;
   logic          pressure_done  = 1'b0;
   int            hold_left      = 0;

   int failures         = 0;
   int counts_queued    = 0;
   int counts_sent      = 0;
   int readings_checked = 0;
   int voltages_seen    = 0;
   int range_errors     = 0;
   int settings_loaded  = 0;
   int cycle_count      = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Runs one edge count through the integrators and, on every sixteenth
   // sample, through the comb stages and the voltage conversion. The old
   // integrator values feed the update, so the order of the adds matters.
   function automatic reading_type filter_edge_count(input logic [CNT_W-1:0] cnt);
      reading_type result;
      logic [31:0] diff1;
      logic [31:0] diff2;
      logic [31:0] diff3;
      logic [31:0] centered;
      logic [31:0] scaled;
      logic [31:0] raw;
      logic [31:0] trimmed;
      result.range_error   = ({16'd0, cnt} < low_limit) || ({16'd0, cnt} > high_limit);
      result.voltage_valid = 1'b0;
      result.voltage_100mv = '0;

      integ_acc[2] = integ_acc[2] + integ_acc[1];
      integ_acc[1] = integ_acc[1] + integ_acc[0];
      integ_acc[0] = integ_acc[0] + {16'd0, cnt};

      if (decim_count == 5'(DECIM - 1)) begin
         diff1        = integ_acc[2] - comb_hist[0];
         comb_hist[0] = integ_acc[2];
         diff2        = diff1 - comb_hist[1];
         comb_hist[1] = diff1;
         diff3        = diff2 - comb_hist[2];
         comb_hist[2] = diff2;

         // Every step wraps at 32 bits, just as the hardware divider sees it.
         centered = FILTER_GAIN * 32'd250 - diff3;
         scaled   = 32'd10 * (centered / 32'd200);
         raw      = (full_scale * scaled) / FILTER_GAIN;
         trimmed  = (raw * calib) / 32'd1000;

         result.voltage_valid = 1'b1;
         result.voltage_100mv = trimmed[15:0];
         decim_count = '0;
      end else begin
         decim_count = decim_count + 5'd1;
      end
      return result;
   endfunction

   // Offers one register write and holds it until the block takes it. The
   // caller lowers csr_valid after the last write so that a run of writes
   // keeps valid high without a glitch.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOW_LIMIT:  low_limit  = {16'd0, value};
         CSR_HIGH_LIMIT: high_limit = {16'd0, value};
         CSR_FULL_SCALE: full_scale = {22'd0, value[9:0]};
         CSR_CALIB:      calib      = {21'd0, value[10:0]};
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] low, input logic [15:0] high,
                                 input logic [9:0] fs, input logic [10:0] cal);
      write_register(CSR_LOW_LIMIT, low);
      write_register(CSR_HIGH_LIMIT, high);
      write_register(CSR_FULL_SCALE, {6'd0, fs});
      write_register(CSR_CALIB, {5'd0, cal});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Returns once a reading has come back for every queued edge count. Each
   // count gives exactly one reading, so nothing is in flight from then on.
   task automatic wait_drained();
      while (readings_checked < counts_queued)
         @(posedge clock);
   endtask

   // Request side. A new item is only chosen once the current one has been
   // taken, so req_tdata never changes under a pending item.
   always @(posedge clock) begin : driver_proc
      int idle_pct;
      idle_pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 15 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(filter_edge_count(req_tdata));
            counts_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_counts.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_tdata  <= pending_counts.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side. Each reading is checked against the oldest expectation.
   // When the pressure phase starts, the monitor holds rsp_tready low for a
   // long stretch so that the output register fills and the block has to
   // push back on its request stream.
   always @(posedge clock) begin : monitor_proc
      reading_type want;
      int stall_pct;
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 47 : (idle_mode == IDLE_BOTH) ? 15 : 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $error("reading with no edge count behind it: tuser %b tdata %0d",
                      rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (want.voltage_valid) voltages_seen++;
               if (want.range_error) range_errors++;
               if (rsp_tuser[0] !== want.range_error) begin
                  $error("range_error: expected %0d, got %0d", want.range_error, rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tuser[1] !== want.voltage_valid) begin
                  $error("voltage_valid: expected %0d, got %0d",
                         want.voltage_valid, rsp_tuser[1]);
                  failures++;
               end
               if (rsp_tdata !== want.voltage_100mv) begin
                  $error("voltage_100mv: expected %0d, got %0d",
                         want.voltage_100mv, rsp_tdata);
                  failures++;
               end
            end
         end
         if (pressure_armed && !pressure_done) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached with %0d readings outstanding",
                  CYCLE_LIMIT, expected_readings.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus_proc
      logic [15:0] low;
      logic [15:0] high;
      int          base_level;
      int          level;
      int          pick;
      logic [15:0] sample;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset defaults: both ends of the count range,
      // each side of both limits, alternating bit patterns, and a steady
      // tail so that the sixteenth sample lands on a decimation point.
      idle_mode = IDLE_NONE;
      pending_counts = '{16'd0, 16'hFFFF, 16'd39, 16'd40, 16'd41, 16'd499, 16'd500,
                         16'd501, 16'd1, 16'h8000, 16'h5555, 16'hAAAA, 16'd250,
                         16'd250, 16'd250, 16'd250};
      counts_queued += pending_counts.size();
      wait_drained();

      // Crossed limits: each test still applies on its own, so every count
      // is flagged. Full scale sits at its maximum and calibration at 2000.
      apply_settings(16'd500, 16'd40, 10'd1023, 11'd2000);
      pending_counts = '{16'd39, 16'd40, 16'd41, 16'd499, 16'd500, 16'd501, 16'd0,
                         16'hFFFF, 16'd270};
      counts_queued += pending_counts.size();
      wait_drained();

      // Random phases. The first two load the register extremes; the
      // second one also uses crossed limits and zero calibration. Each
      // phase runs its own idle pattern.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            apply_settings(16'd0, 16'hFFFF, 10'd1023, 11'd2000);
         end else if (phase == 1) begin
            apply_settings(16'hFFFF, 16'd0, 10'd1, 11'd0);
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               low  = 16'($urandom);
               high = 16'($urandom);
            end else begin
               low  = 16'($urandom_range(0, 300));
               high = low + 16'($urandom_range(0, 500));
            end
            apply_settings(low, high, 10'($urandom_range(1, 1023)),
                           11'($urandom_range(0, 2000)));
         end

         idle_mode = idle_mode_type'(phase % 4);
         if (phase == 2) pressure_armed = 1'b1;

         // Nearly half the samples follow a steady level with some jitter, as a real
         // bitstream would, so the decimated voltage stays meaningful. The
         // rest probe the limits or take any 16-bit value, which also
         // drives the integrators and the conversion into wrap-around.
         base_level = int'($urandom_range(0, 600));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 45) begin
               level  = base_level + int'($urandom_range(0, 16)) - 8;
               sample = (level < 0) ? 16'd0 : 16'(level);
            end else if (pick < 65) begin
               sample = ($urandom_range(0, 1) ? low_limit[15:0] : high_limit[15:0])
                        + 16'($urandom_range(0, 2)) - 16'd1;
            end else if (pick < 80) begin
               sample = 16'($urandom_range(0, 600));
            end else begin
               sample = 16'($urandom);
            end
            pending_counts.push_back(sample);
            counts_queued++;
         end
         wait_drained();
      end

      // Let any stray reading show up before the verdict.
      repeat (150) @(posedge clock);

      $display("Checked %0d readings from %0d edge counts under %0d register settings.",
               readings_checked, counts_sent, settings_loaded + 1);
      $display("They held %0d voltages and %0d range errors; one hold-off of %0d cycles.",
               voltages_seen, range_errors, HOLD_CYCLES);
      if (failures == 0 && expected_readings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/sdv_pkg.sv
design/sdv_integ_cell.sv
design/sdv_comb_cell.sv
design/sdv_div.sv
design/sdv_conv.sv
design/sinc3_decimator_voltage.sv
design/sdv_checker.sv
test/sinc3_decimator_voltage_test.sv
